// ===== rtl/glzw_pkg.sv =====
package glzw_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int KEY_BITS = 20;
   localparam int CODE_BITS = 12;
   localparam int NEXT_BITS = 13;
   localparam int WIDTH_BITS = 4;
   localparam int EPOCH_BITS = 8;
   localparam int BUF_BITS = 20;
   localparam int COUNT_BITS = 5;

   localparam logic [WIDTH_BITS-1:0] MAX_CODE_WIDTH = 4'd12;
   localparam logic [NEXT_BITS-1:0] NEXT_CODE_MAX = 13'd8191;

   localparam logic [1:0] CSR_MIN_CODE_SIZE = 2'd0;
   localparam logic [1:0] CSR_CLEAR_POINT = 2'd1;
   localparam logic [1:0] CSR_START_WITH_CLEAR = 2'd2;

   // One slot of the hash table: the key, the latest code that holds it, and
   // the generation in which it was written.
   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [KEY_BITS-1:0] key;
      logic [CODE_BITS-1:0] code;
   } entry_type;

   // A code handed from the controller to the bit packer.
   typedef struct packed {
      logic valid;
      logic [CODE_BITS-1:0] code;
      logic [WIDTH_BITS-1:0] width;
      logic flush;
   } push_type;

endpackage

// ===== rtl/glzw_table.sv =====
module glzw_table
   import glzw_pkg::*;
#(
   parameter int ADDR_BITS = 13
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output entry_type rd_data,
   input  logic wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  entry_type wr_data
);

   entry_type mem [2**ADDR_BITS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/glzw_packer.sv =====
module glzw_packer
   import glzw_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  push_type push,
   output logic push_ready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic rsp_tlast
);

   logic [BUF_BITS-1:0] buf_ff, buf_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic flush_ff, flush_in;
   logic valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic last_ff, last_in;
   logic [CODE_BITS-1:0] mask;
   logic slot_free;
   logic drain;
   logic final_byte;

   assign push_ready = (count_ff < COUNT_BITS'(8)) && !flush_ff;
   assign slot_free = !valid_ff || rsp_tready;
   assign drain = slot_free &&
                  ((count_ff >= COUNT_BITS'(8)) || (flush_ff && count_ff != '0));
   assign final_byte = flush_ff && (count_ff <= COUNT_BITS'(8));
   assign mask = CODE_BITS'((13'd1 << push.width) - 13'd1);

   always_comb begin
      buf_in = buf_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in = data_ff;
      last_in = last_ff;
      if (push.valid && push_ready) begin
         buf_in = buf_ff | (BUF_BITS'(push.code & mask) << count_ff);
         count_in = count_ff + COUNT_BITS'(push.width);
         flush_in = push.flush;
      end else if (drain) begin
         valid_in = 1'b1;
         data_in = buf_ff[7:0];
         last_in = final_byte;
         buf_in = buf_ff >> 8;
         count_in = final_byte ? '0 : count_ff - COUNT_BITS'(8);
         if (final_byte) begin
            flush_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         count_ff <= '0;
         flush_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         buf_ff <= buf_in;
         count_ff <= count_in;
         flush_ff <= flush_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;

endmodule

// ===== rtl/gif_lzw_compressor_top.sv =====
// Items are worked one at a time. A pixel that hits on its first hash probe passes
// through accept, read, compare and tail; each further probe adds a read and a compare,
// a miss an emit and an update (a clear code in place of the update), and an end of
// image the end-of-image prefix, end code and done states. A code waits while the packer
// holds 8 or more bits. Reset (synchronous, active high) sweeps the hash table with
// req_tready low; the sweep reruns after 255 new dictionaries as the generation wraps.
module gif_lzw_compressor_top
   import glzw_pkg::*;
#(
   parameter int DICT_DEPTH = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel
   input  logic req_tuser,         // [0] force_break
   input  logic req_tlast,         // end_of_image
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic rsp_tlast,         // last_byte
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [12:0] csr_data
);

   // The dictionary lives in an open-addressed hash table twice the size of
   // the code space, so probing always ends at the key or at a free slot.
   // Each slot keeps the newest code for its key; a slot written in an
   // older generation counts as free, which makes a clear code take effect
   // at once without touching the memory.
   localparam int HT_BITS = $clog2(DICT_DEPTH) + 1;
   localparam int DEPTH_BITS = NEXT_BITS + 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_INITCLR = 4'd2;
   localparam logic [3:0] S_RD = 4'd3;
   localparam logic [3:0] S_CMP = 4'd4;
   localparam logic [3:0] S_EMIT_PFX = 4'd5;
   localparam logic [3:0] S_EMIT_CLR = 4'd6;
   localparam logic [3:0] S_UPD = 4'd7;
   localparam logic [3:0] S_TAIL = 4'd8;
   localparam logic [3:0] S_SWEEP = 4'd9;
   localparam logic [3:0] S_EOI_PFX = 4'd10;
   localparam logic [3:0] S_EOI_END = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [PIXEL_BITS-1:0] pixel_ff, pixel_in;
   logic force_ff, force_in;
   logic eoi_ff, eoi_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic [NEXT_BITS-1:0] next_ff, next_in;
   logic [WIDTH_BITS-1:0] cw_ff, cw_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic sweep_pend_ff, sweep_pend_in;
   logic [HT_BITS-1:0] sweep_ff, sweep_in;
   logic started_ff, started_in;
   logic [HT_BITS-1:0] probe_ff, probe_in;

   logic [WIDTH_BITS-1:0] mcs_ff;
   logic [NEXT_BITS-1:0] clear_point_ff;
   logic swc_ff;

   logic [WIDTH_BITS-1:0] size;
   logic [NEXT_BITS-1:0] clear_code;
   logic [KEY_BITS-1:0] key;
   logic [HT_BITS-1:0] start_slot;
   logic [NEXT_BITS-1:0] next_inc;
   logic slot_empty, slot_match;
   logic bump_wrap;

   entry_type rd_data, wr_data;
   logic rd_en, wr_en;
   logic [HT_BITS-1:0] wr_addr;
   push_type push;
   logic push_ready;

   // Configuration registers; writes are taken at any time.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mcs_ff <= 4'd8;
         clear_point_ff <= 13'd4095;
         swc_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_CODE_SIZE: mcs_ff <= csr_data[WIDTH_BITS-1:0];
            CSR_CLEAR_POINT: clear_point_ff <= csr_data;
            CSR_START_WITH_CLEAR: swc_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Code size outside 2..8 is clamped.
   always_comb begin
      if (mcs_ff < 4'd2) begin
         size = 4'd2;
      end else if (mcs_ff > 4'd8) begin
         size = 4'd8;
      end else begin
         size = mcs_ff;
      end
   end

   assign clear_code = NEXT_BITS'(1) << size;
   assign key = {prefix_ff, pixel_ff};
   assign next_inc = (next_ff < NEXT_CODE_MAX) ? next_ff + 13'd1 : next_ff;

   // Hash of the key that the next accepted pixel forms with the prefix.
   assign start_slot = HT_BITS'(prefix_ff) ^ HT_BITS'(prefix_ff >> HT_BITS) ^
                       HT_BITS'({req_tdata, {(HT_BITS - PIXEL_BITS){1'b0}}});

   assign slot_empty = rd_data.epoch != epoch_ff;
   assign slot_match = !slot_empty && (rd_data.key == key);
   assign bump_wrap = epoch_ff == '1;

   assign req_tready = state_ff == S_IDLE;

   // Codes handed to the packer, one per state that emits.
   always_comb begin
      push = '0;
      push.width = cw_ff;
      case (state_ff)
         S_INITCLR: begin
            push.valid = 1'b1;
            push.code = CODE_BITS'(clear_code);
         end
         S_EMIT_PFX: begin
            push.valid = 1'b1;
            push.code = prefix_ff;
         end
         S_EMIT_CLR: begin
            push.valid = 1'b1;
            push.code = CODE_BITS'(clear_code);
         end
         S_EOI_PFX: begin
            push.valid = 1'b1;
            push.code = prefix_ff;
         end
         S_EOI_END: begin
            push.valid = 1'b1;
            push.code = CODE_BITS'(clear_code + 13'd1);
            push.flush = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pixel_in = pixel_ff;
      force_in = force_ff;
      eoi_in = eoi_ff;
      prefix_in = prefix_ff;
      next_in = next_ff;
      cw_in = cw_ff;
      epoch_in = epoch_ff;
      sweep_pend_in = sweep_pend_ff;
      sweep_in = sweep_ff;
      started_in = started_ff;
      probe_in = probe_ff;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_addr = probe_ff;
      wr_data = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pixel_in = req_tdata;
               force_in = req_tuser;
               eoi_in = req_tlast;
               probe_in = start_slot;
               state_in = started_ff ? S_RD : S_INIT;
            end
         end
         S_INIT: begin
            // A new image starts a fresh dictionary generation.
            next_in = clear_code + 13'd1;
            cw_in = size + 4'd1;
            prefix_in = CODE_BITS'(pixel_ff);
            started_in = 1'b1;
            if (bump_wrap) begin
               sweep_pend_in = 1'b1;
            end else begin
               epoch_in = epoch_ff + 1'b1;
            end
            state_in = swc_ff ? S_INITCLR : S_TAIL;
         end
         S_INITCLR: begin
            if (push_ready) begin
               state_in = S_TAIL;
            end
         end
         S_RD: begin
            rd_en = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (slot_empty || slot_match) begin
               if (slot_match && !force_ff) begin
                  prefix_in = rd_data.code;
                  state_in = S_TAIL;
               end else begin
                  state_in = S_EMIT_PFX;
               end
            end else begin
               probe_in = probe_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_EMIT_PFX: begin
            if (push_ready) begin
               state_in = (next_ff == clear_point_ff) ? S_EMIT_CLR : S_UPD;
            end
         end
         S_EMIT_CLR: begin
            if (push_ready) begin
               cw_in = size + 4'd1;
               next_in = clear_code + 13'd1;
               prefix_in = CODE_BITS'(pixel_ff);
               if (bump_wrap) begin
                  sweep_pend_in = 1'b1;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
               state_in = S_TAIL;
            end
         end
         S_UPD: begin
            // The probe stopped on the slot that holds the key or on a free
            // one, so the new code lands there either way.
            next_in = next_inc;
            if (DEPTH_BITS'(next_inc) < DEPTH_BITS'(DICT_DEPTH)) begin
               wr_en = 1'b1;
               wr_data.epoch = epoch_ff;
               wr_data.key = key;
               wr_data.code = CODE_BITS'(next_inc);
            end
            if ((DEPTH_BITS'(next_inc) >= (DEPTH_BITS'(1) << cw_ff)) &&
                (cw_ff < MAX_CODE_WIDTH)) begin
               cw_in = cw_ff + 4'd1;
            end
            prefix_in = CODE_BITS'(pixel_ff);
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (sweep_pend_ff) begin
               sweep_in = '0;
               state_in = S_SWEEP;
            end else begin
               state_in = eoi_ff ? S_EOI_PFX : S_IDLE;
            end
         end
         S_SWEEP: begin
            wr_en = 1'b1;
            wr_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               epoch_in = EPOCH_BITS'(1);
               sweep_pend_in = 1'b0;
               state_in = S_TAIL;
            end
         end
         S_EOI_PFX: begin
            if (push_ready) begin
               state_in = S_EOI_END;
            end
         end
         S_EOI_END: begin
            if (push_ready) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The packer is ready again once the partial word has gone out.
            if (push_ready) begin
               started_in = 1'b0;
               eoi_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         eoi_ff <= 1'b0;
         prefix_ff <= '0;
         next_ff <= 13'd257;
         cw_ff <= 4'd9;
         epoch_ff <= '0;
         sweep_pend_ff <= 1'b1;
         sweep_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         eoi_ff <= eoi_in;
         prefix_ff <= prefix_in;
         next_ff <= next_in;
         cw_ff <= cw_in;
         epoch_ff <= epoch_in;
         sweep_pend_ff <= sweep_pend_in;
         sweep_ff <= sweep_in;
         started_ff <= started_in;
      end
      pixel_ff <= pixel_in;
      force_ff <= force_in;
      probe_ff <= probe_in;
   end

   glzw_table #(
      .ADDR_BITS(HT_BITS)
   ) u_table (
      .clock(clock),
      .rd_en(rd_en),
      .rd_addr(probe_ff),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   glzw_packer u_packer (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_ready(push_ready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

// ===== rtl/glzw_checker.sv =====
module glzw_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic rsp_tlast
);

   // A stalled output word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output word changed while stalled");

   // The table sweep after reset keeps the input closed.
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input open right after reset");

   // Items are worked one at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open the cycle after an accept");

   // An output word never appears in the cycle right after reset.
   a_no_early_word: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output word right after reset");

endmodule

bind gif_lzw_compressor_top glzw_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
